// ===== src/dmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Density matrix block entry package
// Shared widths, operation, error and register codes, and the controller state type.
// ----------------------------------------------------------------------------
package dmb_pkg;

  localparam int LBL_W  = 16;
  localparam int CNT_W  = 13;
  localparam int AMP_W  = 32;
  localparam int MAPV_W = 13;
  localparam int ACC_W  = 64;
  localparam int SYS_W  = 2 * LBL_W + CNT_W;
  localparam int COMB_W = 2 * LBL_W;
  // Packed index: two 32-bit products, a third one and a 16-bit label.
  localparam int PK_W   = 35;

  localparam logic [2:0] OP_AMP   = 3'd0;
  localparam logic [2:0] OP_SYS   = 3'd1;
  localparam logic [2:0] OP_COMB  = 3'd2;
  localparam logic [2:0] OP_MAP   = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_TOTAL  = 3'd1;
  localparam logic [2:0] ERR_RANGE  = 3'd2;
  localparam logic [2:0] ERR_COUNT  = 3'd3;
  localparam logic [2:0] ERR_ENV    = 3'd4;
  localparam logic [2:0] ERR_ABSENT = 3'd5;

  localparam logic [2:0] REG_BLOCK_OFFSET   = 3'd0;
  localparam logic [2:0] REG_BLOCK_SIZE     = 3'd1;
  localparam logic [2:0] REG_WEIGHT_LL      = 3'd2;
  localparam logic [2:0] REG_WEIGHT_LR      = 3'd3;
  localparam logic [2:0] REG_WEIGHT_RR      = 3'd4;
  localparam logic [2:0] REG_SYSTEM_COUNT   = 3'd5;
  localparam logic [2:0] REG_COMBINED_COUNT = 3'd6;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SYS_RD, ST_SYS_WR,
    ST_Q0, ST_Q1, ST_Q2, ST_BR1, ST_BR2, ST_BC1, ST_BC2,
    ST_CI, ST_CD, ST_PR, ST_PC, ST_MR, ST_MD, ST_AD, ST_DONE
  } state_t;

endpackage

// ===== src/dmb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module dmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                      rdata_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                      rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ===== src/dmb_mac.sv =====
// ----------------------------------------------------------------------------
// Saturating multiply-accumulate
// Registered signed product, then a saturating add into a 64-bit sum.
// ----------------------------------------------------------------------------
module dmb_mac
  import dmb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clr,
  input  logic                    mul_en,
  input  logic signed [AMP_W-1:0] a,
  input  logic signed [AMP_W-1:0] b,
  output logic signed [ACC_W-1:0] acc
);

  logic                    prod_v_r;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] sum;
  logic                    ovf;

  assign sum = acc_r + prod_r;
  assign ovf = (acc_r[ACC_W-1] == prod_r[ACC_W-1]) && (sum[ACC_W-1] != prod_r[ACC_W-1]);
  assign acc = acc_r;

  always_ff @(posedge clk) begin
    prod_r <= ACC_W'(a) * ACC_W'(b);
    if (!rst_n || clr) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= mul_en;
      if (prod_v_r) begin
        if (ovf) begin
          acc_r <= prod_r[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          acc_r <= sum;
        end
      end
    end
  end

endmodule

// ===== src/density_matrix_block_entry.sv =====
// ----------------------------------------------------------------------------
// Density matrix block entry
// Load stores of amplitudes, system and combined states and an inverse map,
// then answer queries for one saturated entry of a density matrix block.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Moves
//  in_      input      in_valid/in_stall   load or query transaction
//  out_     output     out_valid/out_stall value and error of a query
//  cfg_     input      cfg_valid/cfg_ready register write (index, data)
//
// A query occupies the block from the cycle in which it is accepted; its
// duration grows with n, the environment count of the row, since each
// environment step is a sequence of reads through the combined, map and
// amplitude memories. A query stopped by an error ends sooner, soonest
// when an early check fails. The result register is loaded in ST_DONE.
// A system-state load is a read-modify-write of the offset table
// (ST_SYS_RD, ST_SYS_WR); the other loads are written on acceptance.
// After reset the inverse map is swept to "absent", one entry a cycle over
// all MAP_DEPTH entries; in_stall stays high meanwhile, cfg writes are accepted.
// A finished result waits in the output register while the next transaction
// is taken; a query finishing while that register is still full waits.
// ----------------------------------------------------------------------------
module density_matrix_block_entry
  import dmb_pkg::*;
#(
  parameter int AMP_DEPTH  = 4096,
  parameter int SYS_DEPTH  = 1024,
  parameter int COMB_DEPTH = 4096,
  parameter int MAP_DEPTH  = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_operation,
  input  logic [15:0]              in_address,
  input  logic signed [AMP_W-1:0]  in_amplitude,
  input  logic [LBL_W-1:0]         in_label_ll,
  input  logic [LBL_W-1:0]         in_label_lr,
  input  logic [CNT_W-1:0]         in_env_count,
  input  logic [LBL_W-1:0]         in_label_rr,
  input  logic [LBL_W-1:0]         in_label_rl,
  input  logic signed [MAPV_W-1:0] in_map_index,
  input  logic [9:0]               in_row,
  input  logic [9:0]               in_col,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0]  out_value,
  output logic [2:0]               out_error,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam int AAW   = (AMP_DEPTH > 1) ? $clog2(AMP_DEPTH) : 1;
  localparam int SAW   = (SYS_DEPTH > 1) ? $clog2(SYS_DEPTH) : 1;
  localparam int CAW   = (COMB_DEPTH > 1) ? $clog2(COMB_DEPTH) : 1;
  localparam int MAW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  // Offsets sum at most SYS_DEPTH environment counts.
  localparam int OFS_W = SAW + CNT_W;
  localparam int IX_W  = OFS_W + 1;

  // Configuration registers.
  logic [10:0]      cfg_off_r, cfg_size_r, cfg_sys_r;
  logic [LBL_W-1:0] cfg_wll_r, cfg_wlr_r, cfg_wrr_r;
  logic [12:0]      cfg_comb_r;

  state_t state_r, state_nxt;

  logic [MAW-1:0]   clr_r;
  logic [15:0]      ld_addr_r;
  logic [LBL_W-1:0] ld_ll_r, ld_lr_r;
  logic [CNT_W-1:0] ld_cnt_r;
  logic [9:0]       q_row_r, q_col_r;
  logic [11:0]      rb_r, cb_r;
  logic [LBL_W-1:0] llr_r, lrr_r, llc_r, lrc_r;
  logic [CNT_W-1:0] n_r, i_r;
  logic [OFS_W-1:0] orow_r, ocol_r;
  logic [PK_W-1:0]  base_r, basec_r, pr_r, pc_r;
  logic [2:0]       err_r;
  logic             err_set;
  logic [2:0]       err_code;

  logic                    out_valid_r;
  logic signed [ACC_W-1:0] out_value_r;
  logic [2:0]              out_error_r;

  logic in_acc, out_free;
  logic [IX_W-1:0] ir, ic;
  logic [OFS_W-1:0] off_sc;

  // Memory ports.
  logic              amp_we, sys_we, off_we, comb_we, map_we;
  logic [AAW-1:0]    amp_wa, amp_ra_a, amp_ra_b;
  logic [AMP_W-1:0]  amp_rd_a, amp_rd_b;
  logic [SAW-1:0]    sys_wa, off_ra_a;
  logic [SYS_W-1:0]  sys_rd_a, sys_rd_b;
  logic [OFS_W-1:0]  off_wd, off_rd_a, off_rd_b;
  logic [CAW-1:0]    comb_wa;
  logic [COMB_W-1:0] comb_rd_a, comb_rd_b;
  logic [MAW-1:0]    map_wa;
  logic [MAPV_W-1:0] map_wd, map_rd_a, map_rd_b;

  // Shared label multiplier.
  logic [LBL_W-1:0]   mul_a, mul_b;
  logic [2*LBL_W-1:0] mul_p;

  logic signed [ACC_W-1:0] acc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  assign ir     = IX_W'(orow_r) + IX_W'(i_r);
  assign ic     = IX_W'(ocol_r) + IX_W'(i_r);
  assign off_sc = (cfg_sys_r == 11'd0) ? '0 : off_rd_a;
  assign mul_p  = (2*LBL_W)'(mul_a) * (2*LBL_W)'(mul_b);

  // ---------------- memories ----------------
  assign amp_we   = in_acc && (in_operation == OP_AMP) && (32'(in_address) < AMP_DEPTH);
  assign amp_wa   = AAW'(in_address);
  assign amp_ra_a = AAW'($unsigned(map_rd_a));
  assign amp_ra_b = AAW'($unsigned(map_rd_b));

  dmb_ram #(.WIDTH(AMP_W), .DEPTH(AMP_DEPTH)) u_amp (
    .clk, .we(amp_we), .waddr(amp_wa), .wdata(in_amplitude),
    .raddr_a(amp_ra_a), .rdata_a(amp_rd_a), .raddr_b(amp_ra_b), .rdata_b(amp_rd_b)
  );

  assign sys_we = (state_r == ST_SYS_WR);
  assign sys_wa = SAW'(ld_addr_r);

  dmb_ram #(.WIDTH(SYS_W), .DEPTH(SYS_DEPTH)) u_sys (
    .clk, .we(sys_we), .waddr(sys_wa), .wdata({ld_ll_r, ld_lr_r, ld_cnt_r}),
    .raddr_a(SAW'(rb_r)), .rdata_a(sys_rd_a), .raddr_b(SAW'(cb_r)), .rdata_b(sys_rd_b)
  );

  // Entry k of this memory holds the offset of system state k+1; offset 0 is zero.
  assign off_we = sys_we;
  assign off_wd = ((ld_addr_r == 16'd0) ? '0 : off_rd_a) + OFS_W'(ld_cnt_r);

  dmb_ram #(.WIDTH(OFS_W), .DEPTH(SYS_DEPTH)) u_off (
    .clk, .we(off_we), .waddr(sys_wa), .wdata(off_wd),
    .raddr_a(off_ra_a), .rdata_a(off_rd_a), .raddr_b(SAW'(cb_r - 12'd1)), .rdata_b(off_rd_b)
  );

  assign comb_we = in_acc && (in_operation == OP_COMB) && (32'(in_address) < COMB_DEPTH);
  assign comb_wa = CAW'(in_address);

  dmb_ram #(.WIDTH(COMB_W), .DEPTH(COMB_DEPTH)) u_comb (
    .clk, .we(comb_we), .waddr(comb_wa), .wdata({in_label_rr, in_label_rl}),
    .raddr_a(CAW'(ir)), .rdata_a(comb_rd_a), .raddr_b(CAW'(ic)), .rdata_b(comb_rd_b)
  );

  // The clearing sweep and map loads never overlap: loads wait in IDLE.
  assign map_we = (state_r == ST_CLEAR) ||
                  (in_acc && (in_operation == OP_MAP) && (32'(in_address) < MAP_DEPTH));
  assign map_wa = (state_r == ST_CLEAR) ? clr_r : MAW'(in_address);
  assign map_wd = (state_r == ST_CLEAR) ? {MAPV_W{1'b1}} : in_map_index;

  dmb_ram #(.WIDTH(MAPV_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk, .we(map_we), .waddr(map_wa), .wdata(map_wd),
    .raddr_a(MAW'(pr_r)), .rdata_a(map_rd_a), .raddr_b(MAW'(pc_r)), .rdata_b(map_rd_b)
  );

  dmb_mac u_mac (
    .clk, .rst_n, .clr(state_r == ST_Q2), .mul_en(state_r == ST_AD),
    .a(amp_rd_a), .b(amp_rd_b), .acc(acc)
  );

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_off_r  <= '0;
      cfg_size_r <= '0;
      cfg_wll_r  <= '0;
      cfg_wlr_r  <= '0;
      cfg_wrr_r  <= '0;
      cfg_sys_r  <= '0;
      cfg_comb_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_OFFSET:   cfg_off_r  <= cfg_data[10:0];
        REG_BLOCK_SIZE:     cfg_size_r <= cfg_data[10:0];
        REG_WEIGHT_LL:      cfg_wll_r  <= cfg_data;
        REG_WEIGHT_LR:      cfg_wlr_r  <= cfg_data;
        REG_WEIGHT_RR:      cfg_wrr_r  <= cfg_data;
        REG_SYSTEM_COUNT:   cfg_sys_r  <= cfg_data[10:0];
        REG_COMBINED_COUNT: cfg_comb_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // ---------------- controller ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_set   = 1'b0;
    err_code  = ERR_OK;
    off_ra_a  = SAW'(rb_r - 12'd1);
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == MAW'(MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_SYS && 32'(in_address) < SYS_DEPTH) begin
            state_nxt = ST_SYS_RD;
          end else if (in_operation == OP_QUERY) begin
            state_nxt = ST_Q0;
          end
        end
      end
      ST_SYS_RD: begin
        off_ra_a  = SAW'(ld_addr_r - 16'd1);
        state_nxt = ST_SYS_WR;
      end
      ST_SYS_WR: state_nxt = ST_IDLE;
      ST_Q0: begin
        off_ra_a  = SAW'(cfg_sys_r - 11'd1);
        state_nxt = ST_Q1;
      end
      ST_Q1: begin
        state_nxt = ST_DONE;
        err_set   = 1'b1;
        if (32'(cfg_sys_r) > SYS_DEPTH || 32'(off_sc) != 32'(cfg_comb_r)) begin
          err_code = ERR_TOTAL;
        end else if ({1'b0, q_row_r} >= cfg_size_r || {1'b0, q_col_r} >= cfg_size_r ||
                     rb_r >= {1'b0, cfg_sys_r} || cb_r >= {1'b0, cfg_sys_r}) begin
          err_code = ERR_RANGE;
        end else if (sys_rd_a[CNT_W-1:0] != sys_rd_b[CNT_W-1:0]) begin
          err_code = ERR_COUNT;
        end else begin
          err_set   = 1'b0;
          state_nxt = ST_Q2;
        end
      end
      ST_Q2: state_nxt = ST_BR1;
      ST_BR1: begin
        mul_a = llr_r; mul_b = cfg_wll_r; state_nxt = ST_BR2;
      end
      ST_BR2: begin
        mul_a = lrr_r; mul_b = cfg_wlr_r; state_nxt = ST_BC1;
      end
      ST_BC1: begin
        mul_a = llc_r; mul_b = cfg_wll_r; state_nxt = ST_BC2;
      end
      ST_BC2: begin
        mul_a = lrc_r; mul_b = cfg_wlr_r; state_nxt = ST_CI;
      end
      ST_CI: begin
        if (i_r == n_r) begin
          state_nxt = ST_DONE;
        end else if (32'(ir) >= COMB_DEPTH || 32'(ic) >= COMB_DEPTH) begin
          err_set = 1'b1; err_code = ERR_RANGE; state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CD;
        end
      end
      ST_CD: begin
        if (comb_rd_a != comb_rd_b) begin
          err_set = 1'b1; err_code = ERR_ENV; state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PR;
        end
      end
      ST_PR: begin
        mul_a = comb_rd_a[COMB_W-1:LBL_W]; mul_b = cfg_wrr_r; state_nxt = ST_PC;
      end
      ST_PC: begin
        mul_a = comb_rd_b[COMB_W-1:LBL_W]; mul_b = cfg_wrr_r; state_nxt = ST_MR;
      end
      ST_MR: begin
        if (pr_r >= PK_W'(MAP_DEPTH) || pc_r >= PK_W'(MAP_DEPTH)) begin
          err_set = 1'b1; err_code = ERR_RANGE; state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MD;
        end
      end
      ST_MD: begin
        if (map_rd_a[MAPV_W-1] || map_rd_b[MAPV_W-1]) begin
          err_set = 1'b1; err_code = ERR_ABSENT; state_nxt = ST_DONE;
        end else if (32'(map_rd_a) >= AMP_DEPTH || 32'(map_rd_b) >= AMP_DEPTH) begin
          err_set = 1'b1; err_code = ERR_RANGE; state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_AD;
        end
      end
      ST_AD: state_nxt = ST_CI;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sweep counter and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + MAW'(1);
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_value_r <= (err_r == ERR_OK) ? acc : '0;
      out_error_r <= err_r;
    end
    if (in_acc) begin
      ld_addr_r <= in_address;
      ld_ll_r   <= in_label_ll;
      ld_lr_r   <= in_label_lr;
      ld_cnt_r  <= in_env_count;
      // The entry is symmetric: walk with the smaller index as row.
      if (in_row > in_col) begin
        q_row_r <= in_col;
        q_col_r <= in_row;
        rb_r    <= {1'b0, cfg_off_r} + 12'(in_col);
        cb_r    <= {1'b0, cfg_off_r} + 12'(in_row);
      end else begin
        q_row_r <= in_row;
        q_col_r <= in_col;
        rb_r    <= {1'b0, cfg_off_r} + 12'(in_row);
        cb_r    <= {1'b0, cfg_off_r} + 12'(in_col);
      end
    end
    if (err_set) begin
      err_r <= err_code;
    end else if (state_r == ST_Q0) begin
      err_r <= ERR_OK;
    end
    case (state_r)
      ST_Q1: begin
        {llr_r, lrr_r} <= sys_rd_a[SYS_W-1:CNT_W];
        {llc_r, lrc_r} <= sys_rd_b[SYS_W-1:CNT_W];
        n_r            <= sys_rd_a[CNT_W-1:0];
      end
      ST_Q2: begin
        orow_r <= (rb_r == 12'd0) ? '0 : off_rd_a;
        ocol_r <= (cb_r == 12'd0) ? '0 : off_rd_b;
        i_r    <= '0;
      end
      ST_BR1: base_r  <= PK_W'(mul_p);
      ST_BR2: base_r  <= base_r + PK_W'(mul_p);
      ST_BC1: basec_r <= PK_W'(mul_p);
      ST_BC2: basec_r <= basec_r + PK_W'(mul_p);
      ST_PR:  pr_r    <= base_r + PK_W'(mul_p) + PK_W'(comb_rd_a[LBL_W-1:0]);
      ST_PC:  pc_r    <= basec_r + PK_W'(mul_p) + PK_W'(comb_rd_b[LBL_W-1:0]);
      ST_AD:  i_r     <= i_r + CNT_W'(1);
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input accepted during map sweep");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error != ERR_OK) |-> (out_value == '0))
    else $error("error result carries a nonzero value");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == OP_QUERY) |=> (state_r == ST_Q0))
    else $error("query did not start");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid)
    else $error("finished query produced no result");

endmodule

// ===== verif/dmb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Density matrix block entry checker
// Watches the load/query, result and register channels, keeps its own copy
// of every store and register, predicts each query answer and compares it
// with the result the block returns.
// ----------------------------------------------------------------------------
module dmb_checker
  import dmb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [2:0]               in_operation,
  input  logic [15:0]              in_address,
  input  logic signed [AMP_W-1:0]  in_amplitude,
  input  logic [LBL_W-1:0]         in_label_ll,
  input  logic [LBL_W-1:0]         in_label_lr,
  input  logic [CNT_W-1:0]         in_env_count,
  input  logic [LBL_W-1:0]         in_label_rr,
  input  logic [LBL_W-1:0]         in_label_rl,
  input  logic signed [MAPV_W-1:0] in_map_index,
  input  logic [9:0]               in_row,
  input  logic [9:0]               in_col,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [ACC_W-1:0]  out_value,
  input  logic [2:0]               out_error,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  output int                       mismatches,
  output int                       pending
);

  localparam int AMP_N  = 4096;
  localparam int SYS_N  = 1024;
  localparam int COMB_N = 4096;
  localparam int MAP_N  = 65536;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [2:0]              error;
  } entry_t;

  logic signed [AMP_W-1:0]  amp_mem  [AMP_N];
  logic [LBL_W-1:0]         sys_ll_m [SYS_N];
  logic [LBL_W-1:0]         sys_lr_m [SYS_N];
  logic [CNT_W-1:0]         sys_cnt_m[SYS_N];
  logic [31:0]              offs     [SYS_N + 1];
  logic [LBL_W-1:0]         comb_rr_m[COMB_N];
  logic [LBL_W-1:0]         comb_rl_m[COMB_N];
  logic signed [MAPV_W-1:0] imap     [MAP_N];

  logic [10:0] blk_off  = '0;
  logic [10:0] blk_size = '0;
  logic [15:0] w_ll     = '0;
  logic [15:0] w_lr     = '0;
  logic [15:0] w_rr     = '0;
  logic [10:0] sys_cnt  = '0;
  logic [12:0] comb_cnt = '0;

  entry_t expected_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
    offs[0]    = '0;
    for (int k = 0; k < MAP_N; k++) imap[k] = -13'sd1;
  end

  // Walks the shared environment states of one matrix entry.
  function automatic entry_t density_entry(logic [9:0] r_in, logic [9:0] c_in);
    entry_t                  e;
    longint unsigned         r, c, rb, cb, n, orow, ocol, ir, ic, pr, pc;
    longint                  ar, ac, acc;
    logic signed [ACC_W:0]   nxt;
    e.value = '0;
    e.error = ERR_OK;
    acc     = 0;
    r = (r_in > c_in) ? c_in : r_in;
    c = (r_in > c_in) ? r_in : c_in;
    if (sys_cnt > SYS_N || offs[sys_cnt] != 32'(comb_cnt)) begin
      e.error = ERR_TOTAL;
      return e;
    end
    if (r >= blk_size || c >= blk_size) begin
      e.error = ERR_RANGE;
      return e;
    end
    rb = blk_off + r;
    cb = blk_off + c;
    if (rb >= sys_cnt || cb >= sys_cnt) begin
      e.error = ERR_RANGE;
      return e;
    end
    if (sys_cnt_m[rb] != sys_cnt_m[cb]) begin
      e.error = ERR_COUNT;
      return e;
    end
    n    = sys_cnt_m[rb];
    orow = offs[rb];
    ocol = offs[cb];
    for (longint unsigned i = 0; i < n; i++) begin
      ir = orow + i;
      ic = ocol + i;
      if (ir >= COMB_N || ic >= COMB_N) begin
        e.error = ERR_RANGE;
        return e;
      end
      if (comb_rr_m[ir] != comb_rr_m[ic] || comb_rl_m[ir] != comb_rl_m[ic]) begin
        e.error = ERR_ENV;
        return e;
      end
      pr = 64'(sys_ll_m[rb]) * 64'(w_ll) + 64'(sys_lr_m[rb]) * 64'(w_lr)
         + 64'(comb_rr_m[ir]) * 64'(w_rr) + 64'(comb_rl_m[ir]);
      pc = 64'(sys_ll_m[cb]) * 64'(w_ll) + 64'(sys_lr_m[cb]) * 64'(w_lr)
         + 64'(comb_rr_m[ic]) * 64'(w_rr) + 64'(comb_rl_m[ic]);
      if (pr >= MAP_N || pc >= MAP_N) begin
        e.error = ERR_RANGE;
        return e;
      end
      if (imap[pr] < 0 || imap[pc] < 0) begin
        e.error = ERR_ABSENT;
        return e;
      end
      if (imap[pr] >= AMP_N || imap[pc] >= AMP_N) begin
        e.error = ERR_RANGE;
        return e;
      end
      ar  = amp_mem[imap[pr]];
      ac  = amp_mem[imap[pc]];
      nxt = 65'(acc) + 65'(ar * ac);
      if (nxt[ACC_W] != nxt[ACC_W-1])
        acc = nxt[ACC_W] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      else
        acc = nxt[ACC_W-1:0];
    end
    e.value = acc;
    return e;
  endfunction

  always @(posedge clk) begin
    entry_t got, want;
    if (rst_n) begin
      // Results first: a query taken at this edge cannot be answered at it.
      if (out_valid && !out_stall) begin
        got.value = out_value;
        got.error = out_error;
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing expected: value %h error %0d",
                     $realtime, got.value, got.error);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.error !== want.error) begin
            if (mismatches < 10)
              $display("%0t: mismatch: value %h error %0d, expected value %h error %0d",
                       $realtime, got.value, got.error, want.value, want.error);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLOCK_OFFSET:   blk_off  = cfg_data[10:0];
          REG_BLOCK_SIZE:     blk_size = cfg_data[10:0];
          REG_WEIGHT_LL:      w_ll     = cfg_data;
          REG_WEIGHT_LR:      w_lr     = cfg_data;
          REG_WEIGHT_RR:      w_rr     = cfg_data;
          REG_SYSTEM_COUNT:   sys_cnt  = cfg_data[10:0];
          REG_COMBINED_COUNT: comb_cnt = cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_operation)
          OP_AMP: if (in_address < AMP_N) amp_mem[in_address] = in_amplitude;
          OP_SYS: begin
            if (in_address < SYS_N) begin
              sys_ll_m[in_address]  = in_label_ll;
              sys_lr_m[in_address]  = in_label_lr;
              sys_cnt_m[in_address] = in_env_count;
              offs[in_address + 1]  = offs[in_address] + 32'(in_env_count);
            end
          end
          OP_COMB: begin
            if (in_address < COMB_N) begin
              comb_rr_m[in_address] = in_label_rr;
              comb_rl_m[in_address] = in_label_rl;
            end
          end
          OP_MAP:   imap[in_address] = in_map_index;
          OP_QUERY: expected_q.push_back(density_entry(in_row, in_col));
          default: ;
        endcase
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Density matrix block entry testbench
// Fills the stores, walks the block through several register settings and
// checks every query answer against the checker's own prediction, with
// random idling on both channels and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb
  import dmb_pkg::*;
;

  // One load or query transaction as presented on the input channel.
  typedef struct packed {
    logic [2:0]               op;
    logic [15:0]              addr;
    logic signed [AMP_W-1:0]  amp;
    logic [LBL_W-1:0]         ll;
    logic [LBL_W-1:0]         lr;
    logic [CNT_W-1:0]         cnt;
    logic [LBL_W-1:0]         rr;
    logic [LBL_W-1:0]         rl;
    logic signed [MAPV_W-1:0] mapi;
    logic [9:0]               row;
    logic [9:0]               col;
  } txn_t;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_operation  = OP_AMP;
  logic [15:0]              in_address    = '0;
  logic signed [AMP_W-1:0]  in_amplitude  = '0;
  logic [LBL_W-1:0]         in_label_ll   = '0;
  logic [LBL_W-1:0]         in_label_lr   = '0;
  logic [CNT_W-1:0]         in_env_count  = '0;
  logic [LBL_W-1:0]         in_label_rr   = '0;
  logic [LBL_W-1:0]         in_label_rl   = '0;
  logic signed [MAPV_W-1:0] in_map_index  = '0;
  logic [9:0]               in_row        = '0;
  logic [9:0]               in_col        = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic signed [ACC_W-1:0]  out_value;
  logic [2:0]               out_error;
  logic                     cfg_valid     = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index     = REG_BLOCK_OFFSET;
  logic [15:0]              cfg_data      = '0;

  int mismatches;
  int pending;

  // Stimulus controls shared with the result-side process.
  bit burst    = 1'b0;   // no idling on either side while set
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  int issued   = 0;

  always #2 clk = ~clk;

  density_matrix_block_entry dut (.*);

  dmb_checker u_checker (.*);

  // The run must never hang: the reset sweep, every load and every query
  // at its worst idling fit many times into this budget.
  initial begin
    #20_000_000;
    $display("** density_matrix_block_entry: FAILED **");
    $finish;
  end

  // Result side. Before each result it stalls for a random number of
  // cycles. When asked, it holds off for a long stretch instead, so that
  // the output register fills, the block stalls and in_stall rises.
  initial begin
    int k;
    forever begin
      k = burst ? 0 : $urandom_range(0, 17);
      if (hold_req) begin
        hold_req = 1'b0;
        k = 400;
      end
      if (k != 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Every field but the operation is random, so that unused fields toggle all their bits too.
  function automatic txn_t fresh(logic [2:0] op);
    txn_t t;
    int   m;
    t.op   = op;
    t.addr = 16'($urandom);
    t.amp  = $urandom;
    t.ll   = 16'($urandom);
    t.lr   = 16'($urandom);
    t.cnt  = 13'($urandom_range(0, 4096));
    t.rr   = 16'($urandom);
    t.rl   = 16'($urandom);
    m      = $urandom_range(0, 4096);
    t.mapi = (m == 4096) ? -13'sd1 : 13'(m);
    t.row  = 10'($urandom);
    t.col  = 10'($urandom);
    return t;
  endfunction

  // Presents one transaction and waits for it to be taken. With no gap the
  // valid simply stays high for the next one.
  task automatic issue(txn_t t);
    int gap;
    in_operation <= t.op;
    in_address   <= t.addr;
    in_amplitude <= t.amp;
    in_label_ll  <= t.ll;
    in_label_lr  <= t.lr;
    in_env_count <= t.cnt;
    in_label_rr  <= t.rr;
    in_label_rl  <= t.rl;
    in_map_index <= t.mapi;
    in_row       <= t.row;
    in_col       <= t.col;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    issued++;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic query(int r, int c);
    txn_t t;
    t     = fresh(OP_QUERY);
    t.row = 10'(r);
    t.col = 10'(c);
    issue(t);
  endtask

  // Stops sending and waits until every answer is back. The checker's count
  // is registered, hence the first edge before looking at it. The trailing
  // cycles cover a system-state load still finishing its offset update.
  task automatic quiesce();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  // Writes all registers, in index order, while the block is idle.
  task automatic configure(int bo, int bs, int wll, int wlr, int wrr, int sc, int cc);
    logic [15:0] vals[7];
    vals[REG_BLOCK_OFFSET]   = 16'(bo);
    vals[REG_BLOCK_SIZE]     = 16'(bs);
    vals[REG_WEIGHT_LL]      = 16'(wll);
    vals[REG_WEIGHT_LR]      = 16'(wlr);
    vals[REG_WEIGHT_RR]      = 16'(wrr);
    vals[REG_SYSTEM_COUNT]   = 16'(sc);
    vals[REG_COMBINED_COUNT] = 16'(cc);
    for (int i = 0; i < 7; i++) begin
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One well-formed setting: s system states loaded in ascending order, the
  // combined entries laid out behind the running offsets, then a batch of
  // mostly in-block queries among loads and unused codes. States of a group
  // share the environment count and combined labels, so their environments match;
  // two groups can give count mismatches, a corrupted label an environment
  // mismatch, a wrong total an early error, random weights range or absent errors.
  task automatic scenario(int s, int ngroups, bit corrupt, bit bad_total, bit odd_weights);
    int          gn  [2];
    logic [15:0] prr [2][8];
    logic [15:0] prl [2][8];
    int          grp [8];
    int          off, bo, bs, nq, pick, sel;
    txn_t        t;
    for (int g = 0; g < 2; g++) begin
      gn[g] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      for (int k = 0; k < 8; k++) begin
        prr[g][k] = 16'($urandom_range(0, 1));
        prl[g][k] = 16'($urandom_range(0, 3));
      end
    end
    for (int a = 0; a < s; a++) begin
      grp[a] = $urandom_range(0, ngroups - 1);
      t      = fresh(OP_SYS);
      t.addr = 16'(a);
      t.ll   = 16'($urandom_range(0, 1));
      t.lr   = 16'($urandom_range(0, 1));
      t.cnt  = 13'(gn[grp[a]]);
      issue(t);
    end
    off = 0;
    for (int a = 0; a < s; a++) begin
      for (int k = 0; k < gn[grp[a]]; k++) begin
        t      = fresh(OP_COMB);
        t.addr = 16'(off + k);
        t.rr   = prr[grp[a]][k];
        t.rl   = prl[grp[a]][k];
        if (corrupt && $urandom_range(0, 7) == 0) t.rl = t.rl ^ 16'h1;
        issue(t);
      end
      off += gn[grp[a]];
    end
    quiesce();
    bo = $urandom_range(0, s - 1);
    bs = $urandom_range(1, s - bo);
    if ($urandom_range(0, 7) == 0) bs += 2;
    // Packed index = ll*16 + lr*8 + rr*4 + rl stays below 32, where every
    // map entry has been written and is absent or points at a written amplitude.
    if (odd_weights)
      configure(bo, bs, $urandom, $urandom, $urandom, s, off);
    else
      configure(bo, bs, 16, 8, 4, s, bad_total ? off + 1 : off);
    nq = $urandom_range(10, 18);
    for (int q = 0; q < nq; q++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        query($urandom_range(0, 1023), $urandom_range(0, 1023));
      end else if (pick == 1) begin
        t      = fresh(OP_AMP);
        t.addr = 16'($urandom_range(0, 4095));
        issue(t);
      end else if (pick == 2) begin
        t      = fresh(OP_MAP);
        t.addr = 16'($urandom_range(0, 31));
        sel    = $urandom_range(0, 7);
        if (sel == 0) t.mapi = -13'sd1;
        else t.mapi = 13'($urandom_range(0, 31));
        issue(t);
      end else if (pick == 3) begin
        issue(fresh(3'($urandom_range(5, 7))));
      end else begin
        query($urandom_range(0, bs - 1), $urandom_range(0, bs - 1));
      end
    end
    quiesce();
  endtask

  initial begin
    txn_t t;
    int   sc;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. With the registers at reset the block is empty, so
    // queries fail on the range check before any store is read.
    query(0, 0);
    query(1023, 0);       // row above column: swapped before the checks
    query(1023, 1023);
    for (int op = 5; op < 8; op++) issue(fresh(3'(op)));   // unused codes
    // Loads past the end of their store are dropped; the map load writes its last entry.
    t = fresh(OP_AMP);  t.addr = 16'hFFFF;                      issue(t);
    t = fresh(OP_SYS);  t.addr = 16'hFFFF;                      issue(t);
    t = fresh(OP_COMB); t.addr = 16'd4096;                      issue(t);
    t = fresh(OP_MAP);  t.addr = 16'hFFFF; t.mapi = -13'sd1;    issue(t);

    // Fill the low amplitudes and map entries that the walks use, so no
    // query can ever read an amplitude that was never written. Amplitude
    // extremes sit at the ends of that range.
    burst = 1'b1;
    for (int a = 0; a < 32; a++) begin
      t = fresh(OP_AMP);
      t.addr = 16'(a);
      if (a == 0) t.amp = 32'sh8000_0000;
      if (a == 31) t.amp = 32'sh7FFF_FFFF;
      if (a == 1) t.amp = 32'sh8000_0000;
      issue(t);
    end
    for (int a = 0; a < 32; a++) begin
      t = fresh(OP_MAP);
      t.addr = 16'(a);
      t.mapi = ($urandom_range(0, 19) == 0) ? -13'sd1 : 13'($urandom_range(0, 31));
      issue(t);
    end
    burst = 1'b0;
    quiesce();

    // All registers at their top values: the system count is out of range.
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    query(0, 0);

    // Three full environment counts: the offset table keeps counting past
    // 13 bits, so a total of 4096 must not match 12288.
    for (int a = 0; a < 3; a++) begin
      t = fresh(OP_SYS);
      t.addr = 16'(a);
      t.cnt  = 13'd4096;
      issue(t);
    end
    quiesce();
    configure(0, 3, 0, 0, 0, 3, 4096);
    query(0, 2);

    // A second state whose walk starts beyond the combined store. The first
    // combined entry points at a map entry that stays absent, so the long
    // walk of state 0 ends at its first step.
    t = fresh(OP_SYS);
    t.addr = 16'd1;
    t.cnt  = 13'd8;
    issue(t);
    t = fresh(OP_COMB);
    t.addr = 16'd0;
    t.rr   = 16'd0;
    t.rl   = 16'd4000;
    issue(t);
    quiesce();
    configure(0, 2, 0, 0, 0, 2, 4104);
    query(0, 0);
    query(1, 1);
    query(1, 0);
    quiesce();

    // Random part: well-formed settings with random content.
    sc = 0;
    while (issued < 500) begin
      burst = ($urandom_range(0, 3) == 0);
      if (sc == 2) begin
        // Back-to-back queries against a long stall of the result side.
        burst    = 1'b1;
        hold_req = 1'b1;
      end
      scenario($urandom_range(1, 8),
               ($urandom_range(0, 2) == 0) ? 2 : 1,
               ($urandom_range(0, 3) == 0),
               ($urandom_range(0, 7) == 0),
               ($urandom_range(0, 7) == 0));
      sc++;
    end
    burst = 1'b0;

    quiesce();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("** density_matrix_block_entry: PASSED **");
    else
      $display("** density_matrix_block_entry: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
src/dmb_pkg.sv
src/dmb_ram.sv
src/dmb_mac.sv
src/density_matrix_block_entry.sv
verif/dmb_checker.sv
verif/tb.sv
